[design/yuvrgb_pkg.sv]
package yuvrgb_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int PROD_W = 21;
	localparam int SUM_W  = 23;

	// chroma coefficients in Q12
	localparam logic signed [PROD_W-1:0] COEF_RV = 21'sd5743;
	localparam logic signed [PROD_W-1:0] COEF_GU = 21'sd1411;
	localparam logic signed [PROD_W-1:0] COEF_GV = 21'sd2925;
	localparam logic signed [PROD_W-1:0] COEF_BU = 21'sd7258;
	localparam logic [11:0] Q12_HALF = 12'h800;

	localparam logic [1:0] IDX_LAST_FULL = 2'd3;
	localparam logic [1:0] IDX_LAST_HALF = 2'd1;

	typedef struct packed {
		logic signed [PROD_W-1:0] rv;
		logic signed [PROD_W-1:0] g;
		logic signed [PROD_W-1:0] bu;
		logic [3:0][7:0]          lumas;
		logic                     half;
	} grp_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	function automatic logic [7:0] sat_q12(input logic signed [SUM_W-1:0] s);
		logic [7:0] r;
		if (s[SUM_W-1]) begin
			r = 8'd0;
		end else if (|s[SUM_W-2:20]) begin
			r = 8'hff;
		end else begin
			r = s[19:12];
		end
		return r;
	endfunction

endpackage

[design/yuvrgb_front.sv]
module yuvrgb_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [7:0]           u_chroma,
	input  logic [7:0]                  luma_zero,
	input  logic signed [7:0]           v_chroma,
	input  logic [7:0]                  luma_one,
	input  logic [7:0]                  luma_two,
	input  logic [7:0]                  luma_three,
	input  logic                        half_width_mode,
	output logic                        push,
	input  logic                        push_ready,
	output yuvrgb_pkg::grp_t            grp
);

	logic                                   vld_s1;
	yuvrgb_pkg::grp_t                       grp_s1;
	logic signed [yuvrgb_pkg::PROD_W-1:0]   u_x;
	logic signed [yuvrgb_pkg::PROD_W-1:0]   v_x;
	logic                                   take;

	assign u_x = yuvrgb_pkg::PROD_W'(u_chroma);
	assign v_x = yuvrgb_pkg::PROD_W'(v_chroma);

	assign in_ready = !vld_s1 || push_ready;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// chroma terms are shared by all pixels of a group, so they are formed once here
	always_ff @(posedge clk) begin
		if (take) begin
			grp_s1.rv    <= v_x * yuvrgb_pkg::COEF_RV;
			grp_s1.g     <= -(u_x * yuvrgb_pkg::COEF_GU) - (v_x * yuvrgb_pkg::COEF_GV);
			grp_s1.bu    <= u_x * yuvrgb_pkg::COEF_BU;
			grp_s1.lumas <= {luma_three, luma_two, luma_one, luma_zero};
			grp_s1.half  <= half_width_mode;
		end
	end

	assign push = vld_s1;
	assign grp  = grp_s1;

endmodule

[design/yuvrgb_queue.sv]
module yuvrgb_queue #(
	parameter int DEPTH = yuvrgb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  yuvrgb_pkg::q_ctl_t ctl,
	input  yuvrgb_pkg::grp_t  wr_grp,
	output logic              full,
	output logic              head_valid,
	output yuvrgb_pkg::grp_t  head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

	yuvrgb_pkg::grp_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (cnt_q == CNT_MAX);
	assign head_valid = (cnt_q != '0);
	assign do_push    = ctl.push && !full;
	assign do_pop     = ctl.pop && head_valid;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_MAX)
		else $error("queue fill count beyond depth");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count did not grow on push");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |-> cnt_q != '0)
		else $error("pop from empty queue");

endmodule

[design/yuvrgb_back.sv]
module yuvrgb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  yuvrgb_pkg::grp_t  head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic              last_of_group
);

	logic [1:0]                            idx_q;
	logic                                  out_valid_q;
	logic [7:0]                            red_q;
	logic [7:0]                            green_q;
	logic [7:0]                            blue_q;
	logic                                  last_q;
	logic                                  adv;
	logic                                  is_last;
	logic [7:0]                            luma;
	logic signed [yuvrgb_pkg::SUM_W-1:0]   base;
	logic signed [yuvrgb_pkg::SUM_W-1:0]   sum_r;
	logic signed [yuvrgb_pkg::SUM_W-1:0]   sum_g;
	logic signed [yuvrgb_pkg::SUM_W-1:0]   sum_b;

	assign adv     = !out_valid_q || out_ready;
	assign is_last = head.half ? (idx_q == yuvrgb_pkg::IDX_LAST_HALF)
	                           : (idx_q == yuvrgb_pkg::IDX_LAST_FULL);
	assign pop     = adv && head_valid && is_last;

	assign luma  = head.lumas[idx_q];
	// luma in Q12 plus the rounding half
	assign base  = $signed({3'b000, luma, yuvrgb_pkg::Q12_HALF});
	assign sum_r = base + yuvrgb_pkg::SUM_W'(head.rv);
	assign sum_g = base + yuvrgb_pkg::SUM_W'(head.g);
	assign sum_b = base + yuvrgb_pkg::SUM_W'(head.bu);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && head_valid) begin
			red_q   <= yuvrgb_pkg::sat_q12(sum_r);
			green_q <= yuvrgb_pkg::sat_q12(sum_g);
			blue_q  <= yuvrgb_pkg::sat_q12(sum_b);
			last_q  <= is_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign red           = red_q;
	assign green         = green_q;
	assign blue          = blue_q;
	assign last_of_group = last_q;

	a_half_idx: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && head.half |-> idx_q <= yuvrgb_pkg::IDX_LAST_HALF)
		else $error("pixel index past second pixel in half-width group");
	a_idx_reset_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 2'd0)
		else $error("pixel index not cleared after group end");

endmodule

[design/yuv411_group_to_rgb.sv]
// channel  | beat                                            | handshake
// ---------+-------------------------------------------------+------------------
// in       | u_chroma luma_zero v_chroma luma_one/two/three  | in_valid/in_ready
// out      | red green blue last_of_group                    | out_valid/out_ready
// cfg      | cfg_wdata -> half_width_mode                    | cfg_we, no wait
//
// one pixel leaves per cycle unless out_ready or an empty queue holds it up;
// 4 pixels per group (2 in half-width mode); the output register sets the pace;
// chroma products form in the front register and pass queue and output register
// reset clears the mode register, valid flags, queue pointers and pixel index
// front and back stall on their own through a QUEUE_DEPTH-entry group queue
module yuv411_group_to_rgb #(
	parameter int QUEUE_DEPTH = yuvrgb_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [7:0] u_chroma,
	input  logic [7:0]        luma_zero,
	input  logic signed [7:0] v_chroma,
	input  logic [7:0]        luma_one,
	input  logic [7:0]        luma_two,
	input  logic [7:0]        luma_three,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic              last_of_group,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);

	logic                 half_width_mode_q;
	logic                 push;
	logic                 full;
	logic                 head_valid;
	logic                 pop;
	yuvrgb_pkg::grp_t     wr_grp;
	yuvrgb_pkg::grp_t     head;
	yuvrgb_pkg::q_ctl_t   q_ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_mode_q <= 1'b0;
		end else if (cfg_we) begin
			half_width_mode_q <= cfg_wdata;
		end
	end

	yuvrgb_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.u_chroma        (u_chroma),
		.luma_zero       (luma_zero),
		.v_chroma        (v_chroma),
		.luma_one        (luma_one),
		.luma_two        (luma_two),
		.luma_three      (luma_three),
		.half_width_mode (half_width_mode_q),
		.push            (push),
		.push_ready      (!full),
		.grp             (wr_grp)
	);

	assign q_ctl.push = push;
	assign q_ctl.pop  = pop;

	yuvrgb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (q_ctl),
		.wr_grp     (wr_grp),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	yuvrgb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.last_of_group (last_of_group)
	);

endmodule
